// ----- hdl/mandelbrot_escape_iteration_defines.svh -----
// Assertion macros for the Mandelbrot escape-time block
`ifndef MANDELBROT_ESCAPE_ITERATION_DEFINES_SVH
`define MANDELBROT_ESCAPE_ITERATION_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MBE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mbe_pkg.sv -----
// Shared types, constants and helpers for the Mandelbrot escape-time block
`default_nettype none

package mbe_pkg;

    localparam int COORD_W    = 32;
    localparam int WIDE_W     = 64;
    localparam int IDX_W      = 9;
    localparam int CNT_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_GRID_DIM  = 512;
    localparam int DEF_FRAC_BITS = 28;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_IM = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_IM = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT  = 3'd4;

    // -2.25, -1.25, 0.75, 1.25 in Q4.28
    localparam logic signed [COORD_W-1:0] RST_MIN_RE = -32'sd603979776;
    localparam logic signed [COORD_W-1:0] RST_MIN_IM = -32'sd335544320;
    localparam logic signed [COORD_W-1:0] RST_MAX_RE = 32'sd201326592;
    localparam logic signed [COORD_W-1:0] RST_MAX_IM = 32'sd335544320;
    localparam logic [CNT_W-1:0]          RST_LIMIT  = 16'd2000;

    typedef struct packed {
        logic [IDX_W-1:0] column_index;
        logic [IDX_W-1:0] row_index;
    } t_pixel;

    typedef struct packed {
        logic [CNT_W-1:0]          iteration_count;
        logic signed [COORD_W-1:0] point_real;
        logic signed [COORD_W-1:0] point_imag;
    } t_result;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
    } t_core_ctrl;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic fits;
        fits = (&v[WIDE_W-1:COORD_W-1]) | ~(|v[WIDE_W-1:COORD_W-1]);
        if (fits) begin
            return v[COORD_W-1:0];
        end
        return v[WIDE_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mbe_axis_map.sv -----
// Axis mapper: lo + floor((hi - lo) * index / GRID_DIM), digit-wise reciprocal division
`default_nettype none

module mbe_axis_map import mbe_pkg::*; #(
    parameter int GRID_DIM = DEF_GRID_DIM
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [COORD_W-1:0] i_lo,
    input  wire logic signed [COORD_W-1:0] i_hi,
    input  wire logic [IDX_W-1:0]          i_index,
    output logic                           o_done,
    output logic signed [COORD_W-1:0]      o_point
);

    localparam int SPAN_W = COORD_W + 1;
    localparam int PROD_W = SPAN_W + IDX_W + 1;
    localparam int MAG_W  = PROD_W - 1;
    localparam int DIG_W  = 14;
    localparam int DIGITS = (MAG_W + DIG_W - 1) / DIG_W;
    localparam int QUO_W  = DIGITS * DIG_W;
    localparam int SUM_W  = QUO_W + 2;
    localparam int R_W    = $clog2(GRID_DIM);
    localparam int T_W    = DIG_W + R_W;
    localparam int RCP_W  = T_W + 1;
    localparam int RCP_SH = T_W + R_W;
    localparam int RP_W   = 2 * T_W + 1;
    localparam int STEP_W = $clog2(DIGITS);
    // ceil(2^RCP_SH / GRID_DIM): exact floor division for any T_W-bit dividend
    localparam logic [RCP_W-1:0]  RECIP     = RCP_W'(((64'd1 << RCP_SH) + 64'(GRID_DIM)
                                                      - 64'd1) / 64'(GRID_DIM));
    localparam logic [T_W-1:0]    GRID_T    = T_W'(GRID_DIM);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIGITS - 1);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ABS, S_RECIP, S_REM, S_FIX} t_state;

    t_state                     r_state;
    logic signed [SPAN_W-1:0]   r_span;
    logic signed [COORD_W-1:0]  r_lo;
    logic [IDX_W-1:0]           r_idx;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_neg;
    logic [QUO_W-1:0]           r_quo;
    logic [R_W-1:0]             r_rem;
    logic [RP_W-1:0]            r_rprod;
    logic [STEP_W-1:0]          r_step;
    logic                       r_done;
    logic signed [COORD_W-1:0]  r_point;

    logic signed [PROD_W-1:0]   w_prod;
    logic [MAG_W-1:0]           w_mag;
    logic [T_W-1:0]             w_t;
    logic [RP_W-1:0]            w_rprod;
    logic [DIG_W-1:0]           w_qd;
    logic [T_W-1:0]             w_rem;
    logic                       w_inc;
    logic [SUM_W-1:0]           w_off;
    logic signed [SUM_W-1:0]    w_sum;

    assign w_prod  = PROD_W'(r_span) * PROD_W'($signed({1'b0, r_idx}));
    assign w_mag   = r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);
    // one digit of long division: remainder so far with the next DIG_W bits
    assign w_t     = {r_rem, r_quo[QUO_W-1 -: DIG_W]};
    assign w_rprod = RP_W'(w_t) * RP_W'(RECIP);
    assign w_qd    = r_rprod[RCP_SH +: DIG_W];
    assign w_rem   = w_t - T_W'(w_qd) * GRID_T;
    // floor for negatives: -(q + (rem != 0)) = ~q + 1 - inc
    assign w_inc   = r_neg && (r_rem != '0);
    assign w_off   = r_neg ? ~{2'b00, r_quo} : {2'b00, r_quo};
    assign w_sum   = SUM_W'(r_lo) + w_off + {{(SUM_W-1){1'b0}}, (r_neg && !w_inc)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_span  <= SPAN_W'(i_hi) - SPAN_W'(i_lo);
                        r_lo    <= i_lo;
                        r_idx   <= i_index;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg   <= r_prod[PROD_W-1];
                    r_quo   <= QUO_W'(w_mag);
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_RECIP;
                end
                S_RECIP: begin
                    r_rprod <= w_rprod;
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_rem  <= w_rem[R_W-1:0];
                    r_quo  <= {r_quo[QUO_W-DIG_W-1:0], w_qd};
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_FIX;
                    end else begin
                        r_state <= S_RECIP;
                    end
                end
                S_FIX: begin
                    r_point <= sat_coord(WIDE_W'(w_sum));
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_point = r_point;

endmodule

`default_nettype wire

// ----- hdl/mbe_iter_core.sv -----
// Iteration datapath: z = z*z + c with saturation and the |z|^2 < 4 test
`default_nettype none

module mbe_iter_core import mbe_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                      i_clk,
    input  wire t_core_ctrl                i_ctrl,
    input  wire logic signed [COORD_W-1:0] i_cr,
    input  wire logic signed [COORD_W-1:0] i_ci,
    output logic                           o_inside
);

    localparam int TSH = 2 + 2 * FRAC_BITS;
    localparam logic [WIDE_W-1:0] FOUR = (TSH > WIDE_W - 1) ? '1 : (WIDE_W'(1) << TSH);

    logic signed [COORD_W-1:0] r_zr;
    logic signed [COORD_W-1:0] r_zi;
    logic signed [WIDE_W-1:0]  r_rr;
    logic signed [WIDE_W-1:0]  r_ii;
    logic signed [WIDE_W-1:0]  r_ri;

    logic [WIDE_W-1:0]         w_mag;
    logic signed [WIDE_W-1:0]  w_nr;
    logic signed [WIDE_W-1:0]  w_ni;

    assign w_mag    = r_rr + r_ii;
    assign o_inside = (w_mag < FOUR);
    assign w_nr     = ((r_rr - r_ii) >>> FRAC_BITS) + WIDE_W'(i_cr);
    assign w_ni     = (r_ri >>> (FRAC_BITS - 1)) + WIDE_W'(i_ci);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_zr <= i_cr;
            r_zi <= i_ci;
        end else if (i_ctrl.upd) begin
            r_zr <= sat_coord(w_nr);
            r_zi <= sat_coord(w_ni);
        end
        if (i_ctrl.mul) begin
            r_rr <= WIDE_W'(r_zr) * WIDE_W'(r_zr);
            r_ii <= WIDE_W'(r_zi) * WIDE_W'(r_zi);
            r_ri <= WIDE_W'(r_zr) * WIDE_W'(r_zi);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mandelbrot_escape_iteration.sv -----
// Flow: two axis mappings (start, multiply, magnitude, three digit divisions by the grid
// size, each a reciprocal multiply then a remainder step, fix-up, hand-over), a load
// step, then a multiply and an update step per iteration; the last update step makes the
// final test and registers the result with its strobe.
// One item at a time; the receiver cannot stall.
// Synchronous active-low reset restores the window and limit registers and idles.
`default_nettype none
`include "mandelbrot_escape_iteration_defines.svh"

module mandelbrot_escape_iteration import mbe_pkg::*; #(
    parameter int GRID_DIM  = DEF_GRID_DIM,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_pixel                i_pixel,
    output logic                       o_done,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_MAP_RE, S_MAP_IM, S_LOAD, S_MUL, S_UPD} t_state;

    t_state                    r_state;
    logic signed [COORD_W-1:0] r_min_re;
    logic signed [COORD_W-1:0] r_min_im;
    logic signed [COORD_W-1:0] r_max_re;
    logic signed [COORD_W-1:0] r_max_im;
    logic [CNT_W-1:0]          r_limit;
    t_pixel                    r_pixel;
    logic signed [COORD_W-1:0] r_cr;
    logic signed [COORD_W-1:0] r_ci;
    logic [CNT_W-1:0]          r_count;
    logic                      r_map_start;
    logic                      r_done;
    t_result                   r_result;

    logic                      w_map_done;
    logic signed [COORD_W-1:0] w_map_point;
    logic signed [COORD_W-1:0] w_map_lo;
    logic signed [COORD_W-1:0] w_map_hi;
    logic [IDX_W-1:0]          w_map_idx;
    logic                      w_inside;
    logic                      w_continue;
    t_core_ctrl                w_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_re <= RST_MIN_RE;
            r_min_im <= RST_MIN_IM;
            r_max_re <= RST_MAX_RE;
            r_max_im <= RST_MAX_IM;
            r_limit  <= RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MIN_RE: r_min_re <= i_cfg_data;
                REG_MIN_IM: r_min_im <= i_cfg_data;
                REG_MAX_RE: r_max_re <= i_cfg_data;
                REG_MAX_IM: r_max_im <= i_cfg_data;
                REG_LIMIT:  r_limit  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_map_lo  = (r_state == S_MAP_RE) ? r_min_re : r_min_im;
    assign w_map_hi  = (r_state == S_MAP_RE) ? r_max_re : r_max_im;
    assign w_map_idx = (r_state == S_MAP_RE) ? r_pixel.column_index : r_pixel.row_index;

    mbe_axis_map #(
        .GRID_DIM (GRID_DIM)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_map_start),
        .i_lo    (w_map_lo),
        .i_hi    (w_map_hi),
        .i_index (w_map_idx),
        .o_done  (w_map_done),
        .o_point (w_map_point)
    );

    assign w_continue  = (r_count < r_limit) && w_inside;
    assign w_ctrl.load = (r_state == S_LOAD);
    assign w_ctrl.mul  = (r_state == S_MUL);
    assign w_ctrl.upd  = (r_state == S_UPD) && w_continue;

    mbe_iter_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_cr     (r_cr),
        .i_ci     (r_ci),
        .o_inside (w_inside)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map_start <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_map_start <= 1'b0;
            r_done      <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_pixel     <= i_pixel;
                        r_map_start <= 1'b1;
                        r_state     <= S_MAP_RE;
                    end
                end
                S_MAP_RE: begin
                    if (w_map_done) begin
                        r_cr        <= w_map_point;
                        r_map_start <= 1'b1;
                        r_state     <= S_MAP_IM;
                    end
                end
                S_MAP_IM: begin
                    if (w_map_done) begin
                        r_ci    <= w_map_point;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_count <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_continue) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_result.iteration_count <= r_count;
                        r_result.point_real      <= r_cr;
                        r_result.point_imag      <= r_ci;
                        r_done                   <= 1'b1;
                        r_state                  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    `MBE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `MBE_ASSERT_SAME(a_done_idle, o_done, r_state == S_IDLE, "result strobe while still busy")
    `MBE_ASSERT_SAME(a_count_limit, o_done, o_result.iteration_count <= r_limit, "count past limit")
    `MBE_ASSERT_NEXT(a_finish_done, (r_state == S_UPD) && !w_continue, o_done, "item ended without result")
    `MBE_ASSERT_SAME(a_map_owner, w_map_done, (r_state == S_MAP_RE) || (r_state == S_MAP_IM), "stray map done")

endmodule

`default_nettype wire
